FILE: rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and codes for the slotted message FIFO: request and response
// payloads, status codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package smf_pkg;

	// Default geometry of the ring
	localparam int NUM_SLOTS_DEF  = 8;
	localparam int SLOT_BYTES_DEF = 64;

	// Fixed field widths
	localparam int LEN_W = 7;
	localparam int OCC_W = 4;
	localparam int STS_W = 3;

	// Request commands
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Response status codes
	localparam logic [STS_W-1:0] ST_RD_DATA  = 3'd0;
	localparam logic [STS_W-1:0] ST_WR_DONE  = 3'd1;
	localparam logic [STS_W-1:0] ST_WR_FULL  = 3'd2;
	localparam logic [STS_W-1:0] ST_RD_EMPTY = 3'd3;
	localparam logic [STS_W-1:0] ST_WR_TRUNC = 3'd4;

	typedef struct packed {
		logic             cmd;
		logic [7:0]       data_byte;
		logic             last_byte;
		logic [LEN_W-1:0] read_limit;
	} req_item_t;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic [7:0]       out_byte;
		logic             byte_valid;
		logic             last;
		logic [LEN_W-1:0] length;
		logic [OCC_W-1:0] occupancy;
		logic             ring_empty;
		logic             ring_full;
	} rsp_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic wr_accept;   // write request transfer
		logic rd_accept;   // read request transfer
		logic len_take;    // latch clipped read length
		logic byte_issue;  // read next byte from slot memory
		logic byte_emit;   // move fetched byte to the response register
	} smf_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;    // response register can take a new result
		logic ring_empty;  // no committed slot
		logic len_zero;    // clipped read length is zero
		logic issue_done;  // all bytes of the read fetched
		logic emit_last;   // next emitted byte ends the message
	} smf_sts_t;

endpackage

FILE: rtl/smf_ctrl.sv
// ----------------------------------------------------------------------------
// smf_ctrl
// Sequencer for the slotted message FIFO. Accepts requests while idle and
// the response register is free, and steps a read through the length clip
// and the byte stream.
// ----------------------------------------------------------------------------
module smf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_cmd,
	output logic            req_ready,
	input  smf_pkg::smf_sts_t sts,
	output smf_pkg::smf_ctl_t ctl
);
	import smf_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LEN,
		S_STREAM
	} state_t;

	state_t state_q, state_d;
	logic   pend_q, pend_d;

	// Decode commands from state and handshakes
	always_comb begin
		ctl       = '0;
		state_d   = state_q;
		pend_d    = pend_q;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = sts.out_free;
				if (req_valid && sts.out_free) begin
					if (req_cmd == CMD_WRITE) begin
						ctl.wr_accept = 1'b1;
					end else begin
						ctl.rd_accept = 1'b1;
						if (!sts.ring_empty) begin
							state_d = S_LEN;
						end
					end
				end
			end
			S_LEN: begin
				if (sts.out_free) begin
					ctl.len_take = 1'b1;
					pend_d       = 1'b0;
					state_d      = sts.len_zero ? S_IDLE : S_STREAM;
				end
			end
			S_STREAM: begin
				ctl.byte_emit  = pend_q && sts.out_free;
				ctl.byte_issue = !sts.issue_done && (!pend_q || ctl.byte_emit);
				if (ctl.byte_issue) begin
					pend_d = 1'b1;
				end else if (ctl.byte_emit) begin
					pend_d = 1'b0;
				end
				if (ctl.byte_emit && sts.emit_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state and the fetched-byte flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

endmodule

FILE: rtl/smf_dp.sv
// ----------------------------------------------------------------------------
// smf_dp
// Datapath of the slotted message FIFO: ring pointers, fill tracking, slot
// byte and length memories, read stream counters and the response register.
// ----------------------------------------------------------------------------
module smf_dp #(
	parameter int NUM_SLOTS  = smf_pkg::NUM_SLOTS_DEF,
	parameter int SLOT_BYTES = smf_pkg::SLOT_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  smf_pkg::req_item_t req,
	input  smf_pkg::smf_ctl_t  ctl,
	output smf_pkg::smf_sts_t  sts,
	input  logic              rsp_ready,
	output logic              rsp_valid,
	output smf_pkg::rsp_item_t rsp
);
	import smf_pkg::*;

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int OFF_W  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
	localparam int DEPTH  = NUM_SLOTS << OFF_W;
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(NUM_SLOTS);
	localparam logic [LEN_W-1:0]  SLOT_LEN  = LEN_W'(SLOT_BYTES);

	// Memories
	logic [7:0]       byte_mem [DEPTH];
	logic [LEN_W-1:0] len_mem  [NUM_SLOTS];

	// Control registers
	logic [SLOT_W-1:0] wr_idx_q, rd_idx_q;
	logic [CNT_W-1:0]  filled_q, filled_d;
	logic [LEN_W-1:0]  fill_off_q;
	logic              dropping_q, overflowed_q;
	logic              out_valid_q;
	logic [LEN_W-1:0]  rd_cnt_q, em_cnt_q;

	// Payload registers
	logic [SLOT_W-1:0] rd_slot_q;
	logic [LEN_W-1:0]  limit_q, len_rd_q, rd_len_q;
	logic [7:0]        byte_q;
	rsp_item_t         out_q, out_d;
	logic              out_load;

	logic              ring_full, ring_empty;
	logic              start_drop, drop_eff, fits, ovf_eff;
	logic              wr_commit, wr_store, rd_pop;
	logic [LEN_W-1:0]  off_inc, len_cap, len_clip;
	logic [STS_W-1:0]  wr_status;
	logic [SLOT_W-1:0] wr_idx_inc, rd_idx_inc;
	logic [CNT_W+OCC_W-1:0] occ_ext;

	assign ring_full  = filled_q >= FULL_CNT;
	assign ring_empty = filled_q == '0;

	// Write path decode
	assign start_drop = (fill_off_q == '0) && !overflowed_q && !dropping_q && ring_full;
	assign drop_eff   = dropping_q || start_drop;
	assign fits       = fill_off_q < SLOT_LEN;
	assign off_inc    = fits ? fill_off_q + 1'b1 : fill_off_q;
	assign ovf_eff    = overflowed_q || !fits;
	assign wr_store   = ctl.wr_accept && !drop_eff && fits;
	assign wr_commit  = ctl.wr_accept && !drop_eff && req.last_byte;
	assign wr_status  = ovf_eff ? ST_WR_TRUNC : ST_WR_DONE;
	assign rd_pop     = ctl.rd_accept && !ring_empty;

	assign wr_idx_inc = (wr_idx_q == LAST_SLOT) ? '0 : wr_idx_q + 1'b1;
	assign rd_idx_inc = (rd_idx_q == LAST_SLOT) ? '0 : rd_idx_q + 1'b1;

	// Clip stored length to slot size and reader limit
	assign len_cap  = (len_rd_q > SLOT_LEN) ? SLOT_LEN : len_rd_q;
	assign len_clip = (limit_q < len_cap) ? limit_q : len_cap;

	// Occupancy after this step
	always_comb begin
		filled_d = filled_q;
		if (wr_commit) begin
			filled_d = filled_q + 1'b1;
		end else if (rd_pop) begin
			filled_d = filled_q - 1'b1;
		end
	end
	assign occ_ext = {{OCC_W{1'b0}}, filled_d};

	// Build the next response
	always_comb begin
		out_d            = out_q;
		out_load         = 1'b0;
		out_d.out_byte   = '0;
		out_d.byte_valid = 1'b0;
		out_d.last       = 1'b1;
		out_d.occupancy  = occ_ext[OCC_W-1:0];
		out_d.ring_empty = filled_d == '0;
		out_d.ring_full  = filled_d >= FULL_CNT;
		if (ctl.wr_accept) begin
			out_load = 1'b1;
			if (drop_eff) begin
				out_d.status = ST_WR_FULL;
				out_d.length = '0;
			end else begin
				out_d.status = (req.last_byte || !fits) ? wr_status : ST_WR_DONE;
				out_d.length = off_inc;
			end
		end else if (ctl.rd_accept && ring_empty) begin
			out_load     = 1'b1;
			out_d.status = ST_RD_EMPTY;
			out_d.length = '0;
		end else if (ctl.len_take && (len_clip == '0)) begin
			out_load     = 1'b1;
			out_d.status = ST_RD_DATA;
			out_d.length = '0;
		end else if (ctl.byte_emit) begin
			out_load         = 1'b1;
			out_d.status     = ST_RD_DATA;
			out_d.out_byte   = byte_q;
			out_d.byte_valid = 1'b1;
			out_d.last       = (em_cnt_q + 1'b1) == rd_len_q;
			out_d.length     = rd_len_q;
		end
	end

	// Advance pointers, fill state and stream counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q     <= '0;
			rd_idx_q     <= '0;
			filled_q     <= '0;
			fill_off_q   <= '0;
			dropping_q   <= 1'b0;
			overflowed_q <= 1'b0;
			out_valid_q  <= 1'b0;
			rd_cnt_q     <= '0;
			em_cnt_q     <= '0;
		end else begin
			filled_q <= filled_d;
			if (ctl.wr_accept) begin
				if (drop_eff) begin
					dropping_q <= !req.last_byte;
				end else if (req.last_byte) begin
					wr_idx_q     <= wr_idx_inc;
					fill_off_q   <= '0;
					overflowed_q <= 1'b0;
				end else begin
					fill_off_q   <= off_inc;
					overflowed_q <= ovf_eff;
				end
			end
			if (rd_pop) begin
				rd_idx_q <= rd_idx_inc;
			end
			if (ctl.len_take) begin
				rd_cnt_q <= '0;
				em_cnt_q <= '0;
			end else begin
				if (ctl.byte_issue) begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end
				if (ctl.byte_emit) begin
					em_cnt_q <= em_cnt_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Memories and payload registers
	always_ff @(posedge clk) begin
		if (wr_store) begin
			byte_mem[{wr_idx_q, fill_off_q[OFF_W-1:0]}] <= req.data_byte;
		end
		if (wr_commit) begin
			len_mem[wr_idx_q] <= off_inc;
		end
		if (rd_pop) begin
			len_rd_q  <= len_mem[rd_idx_q];
			rd_slot_q <= rd_idx_q;
			limit_q   <= req.read_limit;
		end
		if (ctl.len_take) begin
			rd_len_q <= len_clip;
		end
		if (ctl.byte_issue) begin
			byte_q <= byte_mem[{rd_slot_q, rd_cnt_q[OFF_W-1:0]}];
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign sts.out_free   = !out_valid_q || rsp_ready;
	assign sts.ring_empty = ring_empty;
	assign sts.len_zero   = len_clip == '0;
	assign sts.issue_done = rd_cnt_q == rd_len_q;
	assign sts.emit_last  = (em_cnt_q + 1'b1) == rd_len_q;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

FILE: rtl/slotted_message_fifo.sv
// ----------------------------------------------------------------------------
// slotted_message_fifo
// Ring of message slots: writes store one byte per request and commit a slot
// on the last byte; a read pops the oldest slot and streams its bytes.
// ----------------------------------------------------------------------------
//
//   channel  handshake              payload      direction
//   -------  ---------------------  -----------  ---------
//   request  req_valid / req_ready  req (req_item_t)  in
//   response rsp_valid / rsp_ready  rsp (rsp_item_t)  out
//
// A write request gives one response. A read pops the slot and fetches its
// stored length, clips that length, then fetches the first byte through the
// registered read port of the byte memory and streams one byte per cycle
// while the response register is free. A read of zero bytes gives one response.
// Reset clears pointers, counts and the response valid flag at once; slot
// memories are not cleared and need no clearing pass.
// A low rsp_ready holds the response register and pauses the byte stream.
//
module slotted_message_fifo #(
	parameter int NUM_SLOTS  = smf_pkg::NUM_SLOTS_DEF,
	parameter int SLOT_BYTES = smf_pkg::SLOT_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  smf_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output smf_pkg::rsp_item_t rsp
);
	import smf_pkg::*;

	smf_ctl_t ctl;
	smf_sts_t sts;

	smf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_cmd  (req.cmd),
		.req_ready(req_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	smf_dp #(
		.NUM_SLOTS (NUM_SLOTS),
		.SLOT_BYTES(SLOT_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.ctl      (ctl),
		.sts      (sts),
		.rsp_ready(rsp_ready),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

	// A request transfer only happens when the response register is free
	a_req_needs_free_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> (!rsp_valid || rsp_ready))
		else $error("request accepted while response register stalled");

	// Every write transfer yields a response in the next cycle
	a_write_responds: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req.cmd == CMD_WRITE) |=> rsp_valid)
		else $error("write transfer gave no response");

	// Only streamed read bytes may leave last low
	a_last_on_non_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.byte_valid) |-> rsp.last)
		else $error("non-data response without last");

endmodule

FILE: sim/tb_slotted_message_fifo.sv
// ----------------------------------------------------------------------------
// tb_slotted_message_fifo
// Self-checking bench for the slotted message FIFO. A directed table covers
// empty and zero-length reads, full-ring rejection, truncation and reads that
// overlap a partial message. Random message traffic with random gaps on both
// channels follows. Every response is checked against a ring predictor.
// ----------------------------------------------------------------------------
module tb_slotted_message_fifo;
	timeunit 1ns;
	timeprecision 1ps;

	import smf_pkg::*;

	localparam int NS         = NUM_SLOTS_DEF;
	localparam int SB         = SLOT_BYTES_DEF;
	localparam int RAND_ITEMS = 60;
	localparam int IDLE_LIMIT = 3000;
	localparam int TAIL_WAIT  = 100;

	typedef struct {
		req_item_t it;
		int        count;
		bit        typed;
		rsp_item_t want;
	} stim_row_t;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	// ring state mirrored by the predictor
	logic [7:0] slot_mem [NS*SB];
	int         slot_len [NS];
	int         rd_slot    = 0;
	int         wr_slot    = 0;
	int         filled     = 0;
	int         fill_pos   = 0;
	bit         dropping   = 1'b0;
	bit         overflowed = 1'b0;

	rsp_item_t due_rsp [$];
	stim_row_t dir_rows [$];

	int  errors     = 0;
	int  n_items    = 0;
	int  n_rsp      = 0;
	int  n_writes   = 0;
	int  n_reads    = 0;
	int  n_trunc    = 0;
	int  n_full_rej = 0;
	int  n_empty_rd = 0;
	int  idle_cnt   = 0;
	int  stall_left = 0;
	bit  no_idle    = 1'b0;
	rsp_item_t got_want;

	slotted_message_fifo #(
		.NUM_SLOTS (NS),
		.SLOT_BYTES(SB)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// build one response with the ring flags as they stand now
	function automatic rsp_item_t make_rsp(logic [STS_W-1:0] st, logic [7:0] b, logic v,
		logic lst, int len);
		rsp_item_t r;
		r.status     = st;
		r.out_byte   = b;
		r.byte_valid = v;
		r.last       = lst;
		r.length     = LEN_W'(len);
		r.occupancy  = OCC_W'(filled);
		r.ring_empty = (filled == 0);
		r.ring_full  = (filled >= NS);
		return r;
	endfunction

	// single response with no data, as typed into the table
	function automatic rsp_item_t flag_rsp(logic [STS_W-1:0] st, int len, int occ);
		rsp_item_t r;
		r.status     = st;
		r.out_byte   = 8'h00;
		r.byte_valid = 1'b0;
		r.last       = 1'b1;
		r.length     = LEN_W'(len);
		r.occupancy  = OCC_W'(occ);
		r.ring_empty = (occ == 0);
		r.ring_full  = (occ >= NS);
		return r;
	endfunction

	// advance the ring by one request and queue the responses it causes
	function automatic void ring_step(req_item_t it);
		logic [STS_W-1:0] st;
		int len;
		int slot;
		if (it.cmd == CMD_WRITE) begin
			n_writes++;
			if (fill_pos == 0 && !overflowed && !dropping && filled >= NS)
				dropping = 1'b1;
			if (dropping) begin
				if (it.last_byte)
					dropping = 1'b0;
				n_full_rej++;
				due_rsp.push_back(make_rsp(ST_WR_FULL, 8'h00, 1'b0, 1'b1, 0));
				return;
			end
			if (fill_pos < SB) begin
				slot_mem[wr_slot*SB + fill_pos] = it.data_byte;
				fill_pos++;
				st = ST_WR_DONE;
			end else begin
				overflowed = 1'b1;
				st = ST_WR_TRUNC;
			end
			if (it.last_byte) begin
				len = fill_pos;
				if (overflowed)
					st = ST_WR_TRUNC;
				slot_len[wr_slot] = len;
				wr_slot = (wr_slot + 1) % NS;
				filled++;
				fill_pos = 0;
				overflowed = 1'b0;
			end else begin
				len = fill_pos;
			end
			if (st == ST_WR_TRUNC)
				n_trunc++;
			due_rsp.push_back(make_rsp(st, 8'h00, 1'b0, 1'b1, len));
			return;
		end
		n_reads++;
		if (filled == 0) begin
			n_empty_rd++;
			due_rsp.push_back(make_rsp(ST_RD_EMPTY, 8'h00, 1'b0, 1'b1, 0));
			return;
		end
		slot = rd_slot;
		len = slot_len[slot];
		if (len > SB)
			len = SB;
		if (int'(it.read_limit) < len)
			len = int'(it.read_limit);
		rd_slot = (rd_slot + 1) % NS;
		filled--;
		if (len == 0) begin
			due_rsp.push_back(make_rsp(ST_RD_DATA, 8'h00, 1'b0, 1'b1, 0));
			return;
		end
		for (int i = 0; i < len; i++)
			due_rsp.push_back(make_rsp(ST_RD_DATA, slot_mem[slot*SB + i], 1'b1,
				i + 1 == len, len));
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// present one request and hold it until the transfer
	task automatic send_req(input req_item_t it, input bit typed, input rsp_item_t want);
		int g;
		g = pick_gap();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		n_items++;
		ring_step(it);
		if (typed)
			due_rsp[due_rsp.size()-1] = want;
		@(negedge clk);
	endtask

	// hold the request side until every response is back
	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (due_rsp.size() != 0);
	endtask

	function automatic void add_row(logic cmd, logic [7:0] d, logic lb, int lim, int cnt,
		bit typed, rsp_item_t want);
		stim_row_t row;
		row.it.cmd        = cmd;
		row.it.data_byte  = d;
		row.it.last_byte  = lb;
		row.it.read_limit = LEN_W'(lim);
		row.count         = cnt;
		row.typed         = typed;
		row.want          = want;
		dir_rows.push_back(row);
	endfunction

	function automatic req_item_t rand_read();
		req_item_t it;
		int r;
		r = $urandom_range(0, 9);
		it.cmd        = CMD_READ;
		it.data_byte  = 8'($urandom_range(0, 255));
		it.last_byte  = 1'($urandom_range(0, 1));
		it.read_limit = (r == 0) ? LEN_W'(0) : (r == 1) ? LEN_W'(SB) :
			LEN_W'($urandom_range(1, SB));
		return it;
	endfunction

	// directed table: cmd, data, last, limit, count, typed, expected
	task automatic run_table();
		req_item_t it;
		add_row(CMD_READ,  8'h00, 1'b0, 5,  1, 1, flag_rsp(ST_RD_EMPTY, 0, 0));
		add_row(CMD_WRITE, 8'h00, 1'b1, 0,  1, 1, flag_rsp(ST_WR_DONE, 1, 1));
		add_row(CMD_READ,  8'h00, 1'b0, 0,  1, 1, flag_rsp(ST_RD_DATA, 0, 0));
		add_row(CMD_WRITE, 8'h3C, 1'b1, 64, 1, 0, '0);
		add_row(CMD_WRITE, 8'hFF, 1'b0, 0,  1, 0, '0);
		add_row(CMD_READ,  8'hFF, 1'b1, 64, 1, 0, '0);
		add_row(CMD_WRITE, 8'hC3, 1'b1, 0,  4, 0, '0);
		add_row(CMD_READ,  8'h00, 1'b0, 3,  1, 0, '0);
		add_row(CMD_WRITE, 8'h5A, 1'b1, 0, 66, 1, flag_rsp(ST_WR_TRUNC, SB, 1));
		add_row(CMD_READ,  8'h00, 1'b0, 64, 1, 0, '0);
		add_row(CMD_WRITE, 8'h80, 1'b1, 0,  1, 0, '0);
		add_row(CMD_WRITE, 8'h01, 1'b1, 0,  1, 0, '0);
		add_row(CMD_WRITE, 8'h02, 1'b1, 0,  1, 0, '0);
		add_row(CMD_WRITE, 8'h04, 1'b1, 0,  1, 0, '0);
		add_row(CMD_WRITE, 8'h08, 1'b1, 0,  1, 0, '0);
		add_row(CMD_WRITE, 8'h10, 1'b1, 0,  1, 0, '0);
		add_row(CMD_WRITE, 8'h20, 1'b1, 0,  1, 0, '0);
		add_row(CMD_WRITE, 8'h40, 1'b1, 0,  1, 1, flag_rsp(ST_WR_DONE, 1, NS));
		add_row(CMD_WRITE, 8'h77, 1'b0, 0,  1, 1, flag_rsp(ST_WR_FULL, 0, NS));
		add_row(CMD_READ,  8'h00, 1'b0, 1,  1, 0, '0);
		add_row(CMD_WRITE, 8'h77, 1'b1, 0,  1, 1, flag_rsp(ST_WR_FULL, 0, NS-1));
		add_row(CMD_WRITE, 8'h99, 1'b1, 0,  1, 1, flag_rsp(ST_WR_DONE, 1, NS));
		add_row(CMD_READ,  8'h00, 1'b0, 64, 1, 0, '0);
		foreach (dir_rows[i]) begin
			for (int k = 0; k < dir_rows[i].count; k++) begin
				it = dir_rows[i].it;
				if (dir_rows[i].count > 1) begin
					it.data_byte = it.data_byte + 8'(k);
					it.last_byte = it.last_byte && (k == dir_rows[i].count - 1);
				end
				send_req(it, dir_rows[i].typed && (k == dir_rows[i].count - 1),
					dir_rows[i].want);
			end
		end
	endtask

	// random messages with random content, reads mixed in, some mid-message
	task automatic run_random();
		req_item_t it;
		int base;
		int mlen;
		int r;
		bit paused;
		base = n_items;
		paused = 1'b0;
		while (n_items - base < RAND_ITEMS) begin
			if (!paused && n_items - base >= 25) begin
				wait_drained();
				paused = 1'b1;
			end
			no_idle = (n_items - base >= 35) && (n_items - base < 50);
			r = $urandom_range(0, 99);
			if (r < 40) begin
				send_req(rand_read(), 1'b0, '0);
			end else begin
				r = $urandom_range(0, 99);
				mlen = (r < 80) ? $urandom_range(1, 6) :
					(r < 95) ? $urandom_range(7, SB) : $urandom_range(SB + 1, SB + 6);
				for (int k = 0; k < mlen; k++) begin
					if ($urandom_range(0, 9) == 0)
						send_req(rand_read(), 1'b0, '0);
					it.cmd        = CMD_WRITE;
					it.data_byte  = 8'($urandom_range(0, 255));
					it.last_byte  = (k == mlen - 1);
					it.read_limit = LEN_W'($urandom_range(0, 127));
					send_req(it, 1'b0, '0);
				end
			end
		end
		no_idle = 1'b0;
	endtask

	// stall the response side: mostly short, a few long
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else if (!no_idle && $urandom_range(0, 99) < 25) begin
			rsp_ready <= 1'b0;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
				$urandom_range(0, 2);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// check each response transfer against the oldest expectation
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			n_rsp++;
			if (due_rsp.size() == 0) begin
				if (errors < 10)
					$display("unexpected response at %0t: status %0d byte %02h len %0d",
						$realtime, rsp.status, rsp.out_byte, rsp.length);
				errors++;
			end else begin
				got_want = due_rsp.pop_front();
				if (rsp.status !== got_want.status || rsp.out_byte !== got_want.out_byte ||
					rsp.byte_valid !== got_want.byte_valid || rsp.last !== got_want.last ||
					rsp.length !== got_want.length || rsp.occupancy !== got_want.occupancy ||
					rsp.ring_empty !== got_want.ring_empty ||
					rsp.ring_full !== got_want.ring_full) begin
					if (errors < 10)
						$display("mismatch at %0t (expected/actual): status %0d/%0d ",
							$realtime, got_want.status, rsp.status,
							"byte %02h/%02h valid %0b/%0b last %0b/%0b len %0d/%0d ",
							got_want.out_byte, rsp.out_byte,
							got_want.byte_valid, rsp.byte_valid, got_want.last, rsp.last,
							got_want.length, rsp.length,
							"occ %0d/%0d empty %0b/%0b full %0b/%0b",
							got_want.occupancy, rsp.occupancy,
							got_want.ring_empty, rsp.ring_empty,
							got_want.ring_full, rsp.ring_full);
					errors++;
				end
			end
		end
		// end the run when nothing moves for too long
		if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
			idle_cnt <= 0;
		end else if (idle_cnt >= IDLE_LIMIT) begin
			$display("no transfer for %0d cycles, %0d responses outstanding",
				IDLE_LIMIT, due_rsp.size());
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_table();
		run_random();
		req_valid <= 1'b0;
		while (due_rsp.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (due_rsp.size() != 0)
			errors += due_rsp.size();
		$display("requests: %0d (%0d writes, %0d reads), responses checked: %0d",
			n_items, n_writes, n_reads, n_rsp);
		$display("truncated: %0d, rejected full: %0d, empty reads: %0d, failures: %0d",
			n_trunc, n_full_rej, n_empty_rd, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
